// File: rtl/core/sfd_pkg.sv
// Shared types, constants and codes for the serial radio-control frame decoder.
package sfd_pkg;

	localparam int FRAME_BYTES  = 25;
	localparam int CHANNEL_BITS = 11;
	localparam int NUM_CHANNELS = 10;
	localparam int NUM_STICKS   = 4;
	localparam int CNT_W        = $clog2(FRAME_BYTES);
	localparam int VAL_W        = CHANNEL_BITS + 1;
	localparam int CFG_W        = 11;
	localparam int CFG_IDX_W    = 1;

	localparam int FIRST_CHANNEL_BIT = 8;
	localparam int FLAG_BYTE_INDEX   = 23;
	localparam int FAILSAFE_BIT      = 3;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] END_BYTE    = 8'h00;

	localparam logic signed [VAL_W-1:0] SW_DOWN_VALUE = VAL_W'(783);

	localparam logic [CFG_W-1:0] OFFSET_RESET = CFG_W'(1024);
	localparam logic [CFG_W-1:0] LIMIT_RESET  = CFG_W'(784);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_OFFSET = 1'd0,
		REG_STICK_LIMIT    = 1'd1
	} sfd_reg_t;

	typedef enum logic [1:0] {
		SW_CLEARED = 2'd0,
		SW_UP      = 2'd1,
		SW_DOWN    = 2'd2,
		SW_MIDDLE  = 2'd3
	} sfd_switch_t;

	typedef enum logic [1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_RANGE    = 2'd1,
		STATUS_FAILSAFE = 2'd2
	} sfd_status_t;

	typedef logic [FRAME_BYTES-1:0][7:0] sfd_frame_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} sfd_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] right_stick_horizontal;
		logic signed [VAL_W-1:0] right_stick_vertical;
		logic signed [VAL_W-1:0] left_stick_vertical;
		logic signed [VAL_W-1:0] left_stick_horizontal;
		logic signed [VAL_W-1:0] knob_left;
		logic signed [VAL_W-1:0] knob_right;
		logic [1:0]              switch_a_state;
		logic [1:0]              switch_b_state;
		logic [1:0]              switch_c_state;
		logic [1:0]              switch_d_state;
		logic [1:0]              frame_status;
	} sfd_out_t;

endpackage

// File: rtl/core/sfd_assembler.sv
// Frame assembly: byte counter, frame tracking and the frame byte store.
module sfd_assembler import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  sfd_in_t    in_data,
	input  logic       hold,
	output logic       done_s1,
	output sfd_frame_t frame_s1
);

	logic             active_q;
	logic [CNT_W-1:0] count_q;
	logic             eff_active;
	logic [CNT_W-1:0] eff_count;
	logic             accept;
	logic             last_byte;

	// a finished frame waits in the store until the decoder can take it
	assign in_stall   = done_s1 & hold;
	assign accept     = in_valid & ~in_stall;
	assign eff_active = in_data.frame_start | active_q;
	assign eff_count  = in_data.frame_start ? '0 : count_q;
	assign last_byte  = (eff_count == CNT_W'(FRAME_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			done_s1  <= 1'b0;
		end else begin
			if (!hold)
				done_s1 <= 1'b0;
			if (accept && eff_active) begin
				if (last_byte) begin
					active_q <= 1'b0;
					count_q  <= '0;
					done_s1  <= 1'b1;
				end else begin
					active_q <= 1'b1;
					count_q  <= eff_count + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && eff_active)
			frame_s1[eff_count] <= in_data.rx_byte;
	end

endmodule

// File: rtl/core/sfd_decoder.sv
// Frame check, channel unpacking, centering, range check and the result register.
module sfd_decoder import sfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             done_s1,
	input  sfd_frame_t       frame_s1,
	input  logic [CFG_W-1:0] channel_offset,
	input  logic [CFG_W-1:0] stick_limit,
	output logic             hold,
	output logic             out_valid,
	input  logic             out_stall,
	output sfd_out_t         out_data
);

	logic [FRAME_BYTES*8-1:0]  flat;
	logic signed [VAL_W-1:0]   chan [NUM_CHANNELS];
	logic [1:0]                sw   [NUM_STICKS];
	logic                      frame_ok;
	logic                      failsafe;
	logic                      sticks_ok;
	logic signed [VAL_W:0]     lim_pos;
	logic signed [VAL_W:0]     lim_neg;
	sfd_out_t                  result;

	assign hold     = out_valid & out_stall;
	assign frame_ok = (frame_s1[0] == HEADER_BYTE) && (frame_s1[FRAME_BYTES-1] == END_BYTE);
	assign failsafe = frame_s1[FLAG_BYTE_INDEX][FAILSAFE_BIT];
	assign lim_pos  = $signed({2'b00, stick_limit});
	assign lim_neg  = -lim_pos;

	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++)
			flat[i*8 +: 8] = frame_s1[i];
	end

	// channels are packed LSB first right after the header byte
	always_comb begin
		for (int k = 0; k < NUM_CHANNELS; k++)
			chan[k] = $signed({1'b0, flat[FIRST_CHANNEL_BIT + k*CHANNEL_BITS +: CHANNEL_BITS]})
				- $signed({1'b0, channel_offset});
	end

	always_comb begin
		sticks_ok = 1'b1;
		for (int k = 0; k < NUM_STICKS; k++) begin
			if ((VAL_W+1)'(chan[k]) > lim_pos || (VAL_W+1)'(chan[k]) < lim_neg)
				sticks_ok = 1'b0;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_STICKS; k++) begin
			if (chan[6+k] == '0)
				sw[k] = SW_MIDDLE;
			else if (chan[6+k] == SW_DOWN_VALUE)
				sw[k] = SW_DOWN;
			else
				sw[k] = SW_UP;
		end
	end

	always_comb begin
		if (failsafe) begin
			result              = '0;
			result.frame_status = STATUS_FAILSAFE;
		end else begin
			result.right_stick_horizontal = chan[0];
			result.right_stick_vertical   = chan[1];
			result.left_stick_vertical    = chan[2];
			result.left_stick_horizontal  = chan[3];
			result.knob_left              = chan[4];
			result.knob_right             = chan[5];
			result.switch_a_state         = sw[0];
			result.switch_b_state         = sw[1];
			result.switch_c_state         = sw[2];
			result.switch_d_state         = sw[3];
			result.frame_status           = sticks_ok ? STATUS_VALID : STATUS_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (!hold)
			out_valid <= done_s1 & frame_ok;
	end

	always_ff @(posedge clk) begin
		if (!hold && done_s1)
			out_data <= result;
	end

endmodule

// File: rtl/core/sbus_frame_decoder.sv
// Top level of the serial radio-control frame decoder.
//
//  channel | direction | beat moves                      | handshake
//  in      | into      | sfd_in_t: rx_byte, frame_start  | in_valid / in_stall
//  out     | out of    | sfd_out_t: decoded frame        | out_valid / out_stall
//  cfg     | into      | cfg_index, cfg_data             | cfg_we, no wait
//
// One byte beat per cycle while in_stall is low. The last byte lands in the byte
// store and sets done_s1, then the decoder decodes the store into the output
// register and raises out_valid, unless a stalled result still holds it.
// in_stall rises only while a finished frame waits in the store behind a
// stalled output register.
// Reset clears frame tracking and output valid and loads the register
// defaults; the byte store is not reset.
module sbus_frame_decoder import sfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sfd_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sfd_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] channel_offset_q;
	logic [CFG_W-1:0] stick_limit_q;
	logic             hold;
	logic             done_s1;
	sfd_frame_t       frame_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_offset_q <= OFFSET_RESET;
			stick_limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (sfd_reg_t'(cfg_index))
				REG_CHANNEL_OFFSET: channel_offset_q <= cfg_data;
				REG_STICK_LIMIT:    stick_limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	sfd_assembler u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.hold     (hold),
		.done_s1  (done_s1),
		.frame_s1 (frame_s1)
	);

	sfd_decoder u_dec (
		.clk            (clk),
		.arst_n         (arst_n),
		.done_s1        (done_s1),
		.frame_s1       (frame_s1),
		.channel_offset (channel_offset_q),
		.stick_limit    (stick_limit_q),
		.hold           (hold),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

`ifndef NO_ASSERTIONS
	a_stall_only_behind_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && done_s1))
		else $error("input stalled without a blocked finished frame");

	a_result_from_finished_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(done_s1))
		else $error("result appeared without a finished frame");

	a_failsafe_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_status == STATUS_FAILSAFE) |->
		(out_data.right_stick_horizontal == '0 && out_data.knob_right == '0
		&& out_data.switch_a_state == SW_CLEARED && out_data.switch_d_state == SW_CLEARED))
		else $error("failsafe result carries nonzero values");

	a_live_switch_coded: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_status != STATUS_FAILSAFE) |->
		(out_data.switch_a_state != SW_CLEARED && out_data.switch_b_state != SW_CLEARED
		&& out_data.switch_c_state != SW_CLEARED && out_data.switch_d_state != SW_CLEARED))
		else $error("live frame has a cleared switch code");
`endif

endmodule
